// ===== rtl/table_linear_interpolator_assert.svh =====
// Assertion macros for the table linear interpolator.
// Uses clk_i and rst_ni of the module that includes this file.
`ifndef TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define TLI_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (con)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define TLI_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (con)) \
    else $error("assertion failed");

`else

`define TLI_ASSERT_IMP(lbl, ant, con)
`define TLI_ASSERT_NXT(lbl, ant, con)

`endif

`endif

// ===== rtl/tli_pkg.sv =====
// Shared types and constants of the table linear interpolator.
// No dependencies.
`default_nettype none

package tli_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned DATA_W            = 32;
  localparam int unsigned IDX_W             = 4;
  // quotient bits computed; anything at or above 2^DIV_STEPS saturates
  localparam int unsigned DIV_STEPS         = 34;
  localparam int unsigned CNT_W             = $clog2(DIV_STEPS + 1);

  // source of the pending result
  typedef enum logic [2:0] {
    RES_NONE   = 3'd0,
    RES_PASS   = 3'd1,
    RES_FIRST  = 3'd2,
    RES_CUR    = 3'd3,
    RES_INTERP = 3'd4
  } res_sel_e;

  // controller to datapath
  typedef struct packed {
    logic     wr_en;
    logic     rd_en;
    logic     ld_x;
    logic     save_last;
    logic     save_prev;
    logic     calc_diff;
    logic     calc_abs;
    logic     calc_mul;
    logic     div_init;
    logic     div_step;
    res_sel_e pend_sel;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic desc;
    logic below;
    logic x_lt_cur;
    logic step_zero;
    logic big;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/table_linear_interpolator.sv =====
// Top level of the piecewise linear interpolation lookup table.
// Depends on tli_pkg, tli_ctrl and tli_datapath.
//
// Usage: one input stream carries requests. s_axis_tuser = 0 is a load: it
// writes one table entry (breakpoint and mapped value, signed Q16.16) and
// gives no result; an index at or beyond the table size is dropped.
// s_axis_tuser = 1 maps input_value and gives exactly one result on the
// output stream: the value, a pass-through flag (descending table) and a
// saturation flag.
// Sequence: a load writes the entry while the controller stays idle. A map
// reads the last and first entries, scans the breakpoints, forms the segment
// differences, magnitudes and product, then runs the bit-serial restoring
// divider, one quotient bit per cycle; results that skip the division leave earlier.
// Requests are taken one at a time; a new request is taken while a
// finished result still waits in the output register.
// Reset clears the controller and the output valid; the table holds
// nothing defined until entries are loaded, and a map must only touch
// loaded entries. When the receiver stalls, the result holds in the
// output register and the next map result waits until it is taken.
`default_nettype none

module table_linear_interpolator #(
  parameter int unsigned TABLE_ENTRIES = tli_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // [3:0] entry_index, [35:4] breakpoint_value, [67:36] mapped_point,
  // [99:68] input_value, [103:100] zero
  input  wire logic [103:0]  s_axis_tdata,
  // [0] cmd
  input  wire logic          s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // [31:0] mapped_result
  output logic [31:0]        m_axis_tdata,
  // [0] passed_through, [1] saturated
  output logic [1:0]         m_axis_tuser
);
  import tli_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);

  cmd_t               cmd;
  status_t            status;
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] mapped_result;
  logic               passed_through, saturated;

  tli_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_map_i   (s_axis_tuser),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  tli_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .rd_addr_i          (rd_addr),
    .entry_index_i      (s_axis_tdata[3:0]),
    .breakpoint_value_i (s_axis_tdata[35:4]),
    .mapped_point_i     (s_axis_tdata[67:36]),
    .input_value_i      (s_axis_tdata[99:68]),
    .out_ready_i        (m_axis_tready),
    .status_o           (status),
    .out_valid_o        (m_axis_tvalid),
    .mapped_result_o    (mapped_result),
    .passed_through_o   (passed_through),
    .saturated_o        (saturated)
  );

  assign m_axis_tdata = mapped_result;
  assign m_axis_tuser = {saturated, passed_through};

endmodule

`default_nettype wire

// ===== rtl/tli_datapath.sv =====
// Datapath: table memory, segment arithmetic, serial divider and output register.
// Depends on tli_pkg; driven by tli_ctrl.
`default_nettype none

module tli_datapath #(
  parameter int unsigned TABLE_ENTRIES = tli_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire tli_pkg::cmd_t          cmd_i,
  input  wire logic [AW-1:0]          rd_addr_i,
  input  wire logic [3:0]             entry_index_i,
  input  wire logic signed [31:0]     breakpoint_value_i,
  input  wire logic signed [31:0]     mapped_point_i,
  input  wire logic signed [31:0]     input_value_i,
  input  wire logic                   out_ready_i,
  output tli_pkg::status_t            status_o,
  output logic                        out_valid_o,
  output logic signed [31:0]          mapped_result_o,
  output logic                        passed_through_o,
  output logic                        saturated_o
);
  import tli_pkg::*;

  // table memory, entry = {mapped, breakpoint}
  logic [63:0] mem_q [TABLE_ENTRIES];
  logic [63:0] rd_q;
  logic [31:0] idx_ext;
  logic [AW-1:0] wr_addr;
  logic        wr_ok;

  assign idx_ext = 32'(entry_index_i);
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_ok   = idx_ext < TABLE_ENTRIES;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem_q[wr_addr] <= {mapped_point_i, breakpoint_value_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  logic signed [31:0] rd_b, rd_m;
  assign rd_b = rd_q[31:0];
  assign rd_m = rd_q[63:32];

  // search registers
  logic signed [31:0] x_q, last_b_q, prev_b_q, prev_m_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_x) begin
      x_q <= input_value_i;
    end
    if (cmd_i.save_last) begin
      last_b_q <= rd_b;
    end
    if (cmd_i.save_prev) begin
      prev_b_q <= rd_b;
      prev_m_q <= rd_m;
    end
  end

  // segment differences, 33-bit exact
  logic signed [32:0] delta_q, step_q, mstep_q;
  logic signed [31:0] mcur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_diff) begin
      delta_q <= {rd_b[31], rd_b} - {x_q[31], x_q};
      step_q  <= {rd_b[31], rd_b} - {prev_b_q[31], prev_b_q};
      mstep_q <= {rd_m[31], rd_m} - {prev_m_q[31], prev_m_q};
      mcur_q  <= rd_m;
    end
  end

  // magnitudes and result sign
  logic [32:0] delta_n, step_n, mstep_n;
  logic [31:0] dmag_q, smag_q, mmag_q;
  logic        neg_q;

  assign delta_n = 33'd0 - delta_q;
  assign step_n  = 33'd0 - step_q;
  assign mstep_n = 33'd0 - mstep_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_abs) begin
      dmag_q <= delta_q[32] ? delta_n[31:0] : delta_q[31:0];
      smag_q <= step_q[32]  ? step_n[31:0]  : step_q[31:0];
      mmag_q <= mstep_q[32] ? mstep_n[31:0] : mstep_q[31:0];
      neg_q  <= delta_q[32] ^ mstep_q[32] ^ step_q[32];
    end
  end

  // product of the magnitudes
  logic [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_mul) begin
      prod_q <= dmag_q * mmag_q;
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [31:0] rem_q, rem_d;
  logic [33:0] dvd_q;
  logic        big_q, big;
  logic [32:0] rem_sh;
  logic [33:0] trial;
  logic        ge;

  assign big    = {2'b00, prod_q[63:34]} >= smag_q;
  assign rem_sh = {rem_q, dvd_q[33]};
  assign trial  = {1'b0, rem_sh} - {2'b00, smag_q};
  assign ge     = !trial[33];
  assign rem_d  = ge ? trial[31:0] : rem_sh[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q <= {2'b00, prod_q[63:34]};
      dvd_q <= prod_q[33:0];
      big_q <= big;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[32:0], ge};
    end
  end

  // interpolated result with saturation
  logic signed [35:0] m36, q36, sum;
  logic               sat_hi, sat_lo;
  logic signed [31:0] interp;

  always_comb begin
    m36 = {{4{mcur_q[31]}}, mcur_q};
    q36 = {2'b00, dvd_q};
    sum = neg_q ? (m36 + q36) : (m36 - q36);
    if (big_q) begin
      sat_hi = neg_q;
      sat_lo = !neg_q;
    end else begin
      sat_hi = !sum[35] && (|sum[34:31]);
      sat_lo = sum[35] && !(&sum[34:31]);
    end
    if (sat_hi) begin
      interp = 32'sh7FFF_FFFF;
    end else if (sat_lo) begin
      interp = 32'sh8000_0000;
    end else begin
      interp = sum[31:0];
    end
  end

  // pending result
  logic signed [31:0] pend_res_q;
  logic               pend_pass_q, pend_sat_q;

  always_ff @(posedge clk_i) begin
    case (cmd_i.pend_sel)
      RES_PASS: begin
        pend_res_q  <= x_q;
        pend_pass_q <= 1'b1;
        pend_sat_q  <= 1'b0;
      end
      RES_FIRST: begin
        pend_res_q  <= rd_m;
        pend_pass_q <= 1'b0;
        pend_sat_q  <= 1'b0;
      end
      RES_CUR: begin
        pend_res_q  <= mcur_q;
        pend_pass_q <= 1'b0;
        pend_sat_q  <= 1'b0;
      end
      RES_INTERP: begin
        pend_res_q  <= interp;
        pend_pass_q <= 1'b0;
        pend_sat_q  <= sat_hi || sat_lo;
      end
      default: begin
      end
    endcase
  end

  // output register
  logic               out_valid_q;
  logic signed [31:0] out_res_q;
  logic               out_pass_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_res_q  <= pend_res_q;
      out_pass_q <= pend_pass_q;
      out_sat_q  <= pend_sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign mapped_result_o  = out_res_q;
  assign passed_through_o = out_pass_q;
  assign saturated_o      = out_sat_q;

  // status back to the controller
  always_comb begin
    status_o.desc      = last_b_q < rd_b;
    status_o.below     = x_q < rd_b;
    status_o.x_lt_cur  = x_q < rd_b;
    status_o.step_zero = step_q == 33'sd0;
    status_o.big       = big;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

`default_nettype wire

// ===== rtl/tli_ctrl.sv =====
// Controller: sequences loads, the breakpoint search, the divider and result handoff.
// Depends on tli_pkg and table_linear_interpolator_assert.svh.
`default_nettype none
`include "table_linear_interpolator_assert.svh"

module tli_ctrl #(
  parameter int unsigned TABLE_ENTRIES = tli_pkg::TABLE_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_map_i,
  input  wire tli_pkg::status_t  status_i,
  output logic                   in_ready_o,
  output tli_pkg::cmd_t          cmd_o,
  output logic [AW-1:0]          rd_addr_o
);
  import tli_pkg::*;

  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_CHK0 = 11'b000_0000_0010,
    S_CHK1 = 11'b000_0000_0100,
    S_SCAN = 11'b000_0000_1000,
    S_DIFF = 11'b000_0001_0000,
    S_ABS  = 11'b000_0010_0000,
    S_MUL  = 11'b000_0100_0000,
    S_OVF  = 11'b000_1000_0000,
    S_DIV  = 11'b001_0000_0000,
    S_FIN  = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    rd_addr_o  = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && !in_map_i) begin
          cmd_o.wr_en = 1'b1;
        end else if (in_valid_i) begin
          cmd_o.ld_x  = 1'b1;
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = LAST;
          state_d     = S_CHK0;
        end
      end
      S_CHK0: begin
        cmd_o.save_last = 1'b1;
        cmd_o.rd_en     = 1'b1;
        rd_addr_o       = '0;
        state_d         = S_CHK1;
      end
      S_CHK1: begin
        if (status_i.desc) begin
          cmd_o.pend_sel = RES_PASS;
          state_d        = S_OUT;
        end else if (status_i.below) begin
          cmd_o.pend_sel = RES_FIRST;
          state_d        = S_OUT;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.rd_en     = 1'b1;
          rd_addr_o       = AW'(1);
          idx_d           = AW'(1);
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        // segment ends at the first breakpoint above the input, or the last one
        if (status_i.x_lt_cur || idx_q == LAST) begin
          state_d = S_DIFF;
        end else begin
          cmd_o.save_prev = 1'b1;
          cmd_o.rd_en     = 1'b1;
          rd_addr_o       = idx_q + AW'(1);
          idx_d           = idx_q + AW'(1);
        end
      end
      S_DIFF: begin
        cmd_o.calc_diff = 1'b1;
        state_d         = S_ABS;
      end
      S_ABS: begin
        if (status_i.step_zero) begin
          cmd_o.pend_sel = RES_CUR;
          state_d        = S_OUT;
        end else begin
          cmd_o.calc_abs = 1'b1;
          state_d        = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = S_OVF;
      end
      S_OVF: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = CNT_W'(DIV_STEPS);
        state_d        = status_i.big ? S_FIN : S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.pend_sel = RES_INTERP;
        state_d        = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // checks
  `TLI_ASSERT_NXT(a_map_starts_search, state_q == S_IDLE && in_valid_i && in_map_i, state_q == S_CHK0)
  `TLI_ASSERT_IMP(a_div_count_live, state_q == S_DIV, cnt_q != '0)
  `TLI_ASSERT_IMP(a_scan_in_table, state_q == S_SCAN, idx_q <= LAST && idx_q != '0)
  `TLI_ASSERT_IMP(a_fin_after_div, state_q == S_FIN, $past(state_q) == S_DIV || $past(state_q) == S_OVF)

endmodule

`default_nettype wire
